// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define UBX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked while reset is applied.
`define UBX_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ubx_pkg.sv -----
// Package: codes, constants and types of the frame deframer.
package ubx_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned LEFT_W     = LEN_W + 1;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_SUM,
    ST_INCOMPLETE
  } status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

// ----- rtl/core/ubx_ifs.sv -----
// Interfaces: byte input channel and frame result channel.
interface ubx_in_if;
  logic                          valid;
  logic                          ready;
  logic [ubx_pkg::BYTE_W-1:0]    in_byte;
  logic                          stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface ubx_out_if;
  logic                          valid;
  logic                          ready;
  logic [ubx_pkg::BYTE_W-1:0]    out_byte;
  logic                          in_frame;
  logic                          frame_end;
  logic [1:0]                    frame_status;
  logic [ubx_pkg::BYTE_W-1:0]    msg_class;
  logic [ubx_pkg::BYTE_W-1:0]    msg_id;
  logic [ubx_pkg::LEN_W-1:0]     payload_len;
  logic [ubx_pkg::CNT_W-1:0]     good_frames;
  logic [ubx_pkg::CNT_W-1:0]     bad_frames;

  modport source (output valid, output out_byte, output in_frame, output frame_end,
                  output frame_status, output msg_class, output msg_id,
                  output payload_len, output good_frames, output bad_frames,
                  input ready);
  modport sink (input valid, input out_byte, input in_frame, input frame_end,
                input frame_status, input msg_class, input msg_id,
                input payload_len, input good_frames, input bad_frames,
                output ready);
endinterface

// ----- rtl/core/ubx_frame_deframer.sv -----
// Top level: sync hunt, header capture and Fletcher check of a framed byte stream.
// Throughput: one byte per cycle while the output register is free or being taken;
// each accepted byte's result goes to the output register; the parse state and both
// running sums update in the cycle the byte is accepted; the register frees when taken.
// Reset (synchronous, rst_n low): hunt for the first sync byte, sums, header fields
// and both counters cleared, output register empty.
module ubx_frame_deframer (
  input logic      clk,
  input logic      rst_n,
  ubx_in_if.sink   in_ch,
  ubx_out_if.source out_ch
);
  import ubx_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  logic [BYTE_W-1:0]   sa_r, sa_nxt;
  logic [BYTE_W-1:0]   sb_r, sb_nxt;
  logic [BYTE_W-1:0]   chk_r, chk_nxt;
  logic [BYTE_W-1:0]   cls_r, cls_nxt;
  logic [BYTE_W-1:0]   id_r, id_nxt;
  logic [CNT_W-1:0]    good_r, good_nxt;
  logic [CNT_W-1:0]    bad_r, bad_nxt;

  logic                out_valid_r;
  logic [BYTE_W-1:0]   byte_r;
  logic                mark_r;
  logic                fend_r;
  status_t             status_r;

  logic [BYTE_W-1:0]   b;
  logic                accept;
  logic                mark, fend, synced;
  status_t             status;
  logic [BYTE_W-1:0]   fold_a, fold_b;

  assign b            = in_ch.in_byte;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign fold_a       = sa_r + b;
  assign fold_b       = sb_r + fold_a;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    chk_nxt   = chk_r;
    cls_nxt   = cls_r;
    id_nxt    = id_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;
    mark      = 1'b0;
    fend      = 1'b0;
    synced    = 1'b0;
    status    = ST_OK;
    case (phase_r)
      PH_HUNT: begin
        if (b == SYNC_FIRST) begin
          mark      = 1'b1;
          phase_nxt = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (b == SYNC_SECOND) begin
          mark      = 1'b1;
          synced    = 1'b1;
          sa_nxt    = '0;
          sb_nxt    = '0;
          cls_nxt   = '0;
          id_nxt    = '0;
          len_nxt   = '0;
          phase_nxt = PH_CLASS;
        end else if (b == SYNC_FIRST) begin
          mark = 1'b1;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_CLASS: begin
        mark      = 1'b1;
        synced    = 1'b1;
        cls_nxt   = b;
        sa_nxt    = fold_a;
        sb_nxt    = fold_b;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        mark      = 1'b1;
        synced    = 1'b1;
        id_nxt    = b;
        sa_nxt    = fold_a;
        sb_nxt    = fold_b;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        mark      = 1'b1;
        synced    = 1'b1;
        len_nxt   = {{(LEN_W-BYTE_W){1'b0}}, b};
        sa_nxt    = fold_a;
        sb_nxt    = fold_b;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        mark      = 1'b1;
        synced    = 1'b1;
        len_nxt   = {b, len_r[BYTE_W-1:0]};
        sa_nxt    = fold_a;
        sb_nxt    = fold_b;
        left_nxt  = {1'b0, b, len_r[BYTE_W-1:0]} + LEFT_W'(2);
        phase_nxt = PH_BODY;
      end
      PH_BODY: begin
        mark   = 1'b1;
        synced = 1'b1;
        if (left_r > LEFT_W'(2)) begin
          sa_nxt   = fold_a;
          sb_nxt   = fold_b;
          left_nxt = left_r - LEFT_W'(1);
        end else if (left_r == LEFT_W'(2)) begin
          chk_nxt  = b;
          left_nxt = LEFT_W'(1);
        end else begin
          fend = 1'b1;
          if (chk_r == sa_r && b == sb_r) begin
            status   = ST_OK;
            good_nxt = sat_inc(good_r);
          end else begin
            status  = ST_BAD_SUM;
            bad_nxt = sat_inc(bad_r);
          end
          left_nxt  = '0;
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
    if (in_ch.stream_end) begin
      if (synced && !fend) begin
        fend    = 1'b1;
        status  = ST_INCOMPLETE;
        bad_nxt = sat_inc(bad_r);
      end
      phase_nxt = PH_HUNT;
      left_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      left_r  <= '0;
      sa_r    <= '0;
      sb_r    <= '0;
      chk_r   <= '0;
      cls_r   <= '0;
      id_r    <= '0;
      good_r  <= '0;
      bad_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      sa_r    <= sa_nxt;
      sb_r    <= sb_nxt;
      chk_r   <= chk_nxt;
      cls_r   <= cls_nxt;
      id_r    <= id_nxt;
      good_r  <= good_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r   <= b;
      mark_r   <= mark;
      fend_r   <= fend;
      status_r <= status;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = byte_r;
  assign out_ch.in_frame     = mark_r;
  assign out_ch.frame_end    = fend_r;
  assign out_ch.frame_status = status_r;
  assign out_ch.msg_class    = cls_r;
  assign out_ch.msg_id       = id_r;
  assign out_ch.payload_len  = len_r;
  assign out_ch.good_frames  = good_r;
  assign out_ch.bad_frames   = bad_r;

endmodule

// ----- rtl/core/ubx_chk.sv -----
// Port checker for the frame deframer, bound to its top level.
`include "assert_macros.svh"

module ubx_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ubx_pkg::BYTE_W-1:0] out_byte,
  input logic                       in_frame,
  input logic                       frame_end,
  input logic [1:0]                 frame_status
);
  import ubx_pkg::*;

  `UBX_ASSERT_RST(a_empty_after_reset, !rst_n |=> !out_valid, "result valid after reset")
  `UBX_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_byte), "stalled transaction changed")
  `UBX_ASSERT(a_status_quiet, out_valid && !frame_end |-> frame_status == ST_OK, "status set without frame end")
  `UBX_ASSERT(a_end_in_frame, out_valid && frame_end |-> in_frame && (frame_status == ST_OK || frame_status == ST_BAD_SUM || frame_status == ST_INCOMPLETE), "frame end outside a frame")

endmodule

bind ubx_frame_deframer ubx_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .in_frame     (out_ch.in_frame),
  .frame_end    (out_ch.frame_end),
  .frame_status (out_ch.frame_status)
);

// ----- bench/tb_top.sv -----
// Testbench of the frame deframer: directed rows, random byte streams, checked per transaction.
`timescale 1ns / 1ps

module tb_top;
  import ubx_pkg::*;

  localparam int PLAN_ROWS  = 25;
  localparam int RAND_BYTES = 1950;

  typedef struct packed {
    logic [7:0]  data;
    logic        mark;
    logic        fend;
    status_t     status;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic [31:0] good;
    logic [31:0] bad;
  } frame_rec_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        known;
    logic        mark;
    logic        fend;
    status_t     status;
    logic [31:0] good;
    logic [31:0] bad;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic take_q = 1'b0;
  bit gaps_on = 1'b1;

  ubx_in_if in_ch ();
  ubx_out_if out_ch ();

  assign out_ch.ready = take_q;

  ubx_frame_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // Directed rows: known marks, ends, status codes and counters where they are obvious.
  dir_row_t plan [PLAN_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'hB5, 1'b0, 1'b1, 1'b1, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'hB5, 1'b0, 1'b1, 1'b1, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h62, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'hFD, 1'b0, 1'b1, 1'b1, 1'b1, ST_OK,         32'd1, 32'd0},
    '{8'hB5, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h13, 1'b0, 1'b1, 1'b0, 1'b0, ST_OK,         32'd1, 32'd0},
    '{8'hB5, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h62, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h02, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'hB5, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, ST_BAD_SUM,    32'd1, 32'd1},
    '{8'hB5, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,         32'd0, 32'd0},
    '{8'h62, 1'b1, 1'b1, 1'b1, 1'b1, ST_INCOMPLETE, 32'd1, 32'd2},
    '{8'hB5, 1'b1, 1'b1, 1'b1, 1'b0, ST_OK,         32'd1, 32'd2}
  };

  phase_t      ph;
  logic [15:0] len_q;
  logic [16:0] left_q;
  logic [7:0]  fa, fb, ck_a_q, cls_q, id_q;
  logic [31:0] good_q, bad_q;

  frame_rec_t frame_results_due [$];
  dir_row_t   cur_row;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned ok_seen = 0, sum_err_seen = 0, cut_seen = 0;

  function automatic void fletcher_fold(input logic [7:0] b);
    fa = fa + b;
    fb = fb + fa;
  endfunction

  function automatic logic [31:0] count_up(input logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  task automatic track_stream_byte(input logic [7:0] b, input logic last,
                                   output frame_rec_t r);
    logic mark, fend, synced;
    status_t st;
    mark = 1'b0;
    fend = 1'b0;
    synced = 1'b0;
    st = ST_OK;
    case (ph)
      PH_HUNT: begin
        if (b == SYNC_FIRST) begin
          mark = 1'b1;
          ph = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (b == SYNC_SECOND) begin
          mark = 1'b1;
          synced = 1'b1;
          fa = '0;
          fb = '0;
          cls_q = '0;
          id_q = '0;
          len_q = '0;
          ph = PH_CLASS;
        end else if (b == SYNC_FIRST) begin
          mark = 1'b1;
        end else begin
          ph = PH_HUNT;
        end
      end
      PH_CLASS: begin
        mark = 1'b1;
        synced = 1'b1;
        cls_q = b;
        fletcher_fold(b);
        ph = PH_ID;
      end
      PH_ID: begin
        mark = 1'b1;
        synced = 1'b1;
        id_q = b;
        fletcher_fold(b);
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        mark = 1'b1;
        synced = 1'b1;
        len_q = {8'h00, b};
        fletcher_fold(b);
        ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        mark = 1'b1;
        synced = 1'b1;
        len_q[15:8] = b;
        fletcher_fold(b);
        left_q = {1'b0, len_q} + 17'd2;
        ph = PH_BODY;
      end
      default: begin
        mark = 1'b1;
        synced = 1'b1;
        if (left_q > 17'd2) begin
          fletcher_fold(b);
          left_q = left_q - 17'd1;
        end else if (left_q == 17'd2) begin
          ck_a_q = b;
          left_q = 17'd1;
        end else begin
          fend = 1'b1;
          if (ck_a_q == fa && b == fb) begin
            st = ST_OK;
            good_q = count_up(good_q);
          end else begin
            st = ST_BAD_SUM;
            bad_q = count_up(bad_q);
          end
          left_q = '0;
          ph = PH_HUNT;
        end
      end
    endcase
    if (last) begin
      if (synced && !fend) begin
        fend = 1'b1;
        st = ST_INCOMPLETE;
        bad_q = count_up(bad_q);
      end
      ph = PH_HUNT;
      left_q = '0;
    end
    r = {b, mark, fend, st, cls_q, id_q, len_q, good_q, bad_q};
  endtask

  always @(posedge clk) begin
    take_q <= !rst_n ? 1'b0 : (!gaps_on || $urandom_range(99) >= 30);
  end

  always @(posedge clk) begin : watch
    frame_rec_t got, want, rec;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_byte, out_ch.in_frame, out_ch.frame_end,
             status_t'(out_ch.frame_status), out_ch.msg_class, out_ch.msg_id,
             out_ch.payload_len, out_ch.good_frames, out_ch.bad_frames};
      results_seen++;
      if (got.fend) begin
        case (got.status)
          ST_OK:         ok_seen++;
          ST_BAD_SUM:    sum_err_seen++;
          ST_INCOMPLETE: cut_seen++;
          default: ;
        endcase
      end
      if (frame_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction at %0t: byte=%h", $realtime, got.data);
      end else begin
        want = frame_results_due.pop_front();
        if (got.data !== want.data || got.mark !== want.mark || got.fend !== want.fend ||
            got.status !== want.status || got.cls !== want.cls || got.id !== want.id ||
            got.len !== want.len || got.good !== want.good || got.bad !== want.bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t exp: byte=%h mark=%b end=%b st=%0d cls=%h id=%h len=%h good=%0d bad=%0d",
                     $realtime, want.data, want.mark, want.fend, want.status, want.cls,
                     want.id, want.len, want.good, want.bad);
            $display("               got: byte=%h mark=%b end=%b st=%0d cls=%h id=%h len=%h good=%0d bad=%0d",
                     got.data, got.mark, got.fend, got.status, got.cls,
                     got.id, got.len, got.good, got.bad);
          end
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      track_stream_byte(in_ch.in_byte, in_ch.stream_end, rec);
      if (cur_row.known) begin
        rec.mark = cur_row.mark;
        rec.fend = cur_row.fend;
        rec.status = cur_row.status;
        rec.good = cur_row.good;
        rec.bad = cur_row.bad;
      end
      frame_results_due.push_back(rec);
    end
  end

  task automatic drive_row(input dir_row_t row);
    while (gaps_on && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= row.data;
    in_ch.stream_end <= row.last;
    cur_row <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic e);
    dir_row_t row;
    row = '0;
    row.data = b;
    row.last = e;
    drive_row(row);
  endtask

  // Drop valid and hold off until every transaction has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frame_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(input int unsigned plen, input int unsigned lead_syncs,
                            input bit corrupt, input bit close_stream);
    logic [7:0]  body [$];
    logic [7:0]  ca, cb, flip;
    logic [15:0] len;
    len = plen[15:0];
    ca = '0;
    cb = '0;
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    repeat (plen) begin
      if ($urandom_range(5) == 0)
        body.push_back($urandom_range(1) ? SYNC_FIRST : SYNC_SECOND);
      else
        body.push_back(8'($urandom));
    end
    foreach (body[k]) begin
      ca = ca + body[k];
      cb = cb + ca;
    end
    if (corrupt) begin
      flip = 8'($urandom_range(1, 255));
      if ($urandom_range(1)) ca = ca ^ flip;
      else cb = cb ^ flip;
    end
    repeat (lead_syncs) send_byte(SYNC_FIRST, 1'b0);
    send_byte(SYNC_FIRST, 1'b0);
    send_byte(SYNC_SECOND, 1'b0);
    foreach (body[k]) send_byte(body[k], 1'b0);
    send_byte(ca, 1'b0);
    send_byte(cb, close_stream);
  endtask

  // Cut a frame short anywhere from its first sync byte onwards.
  task automatic send_cut_frame();
    logic [7:0] seq [$];
    int unsigned cut;
    seq.push_back(SYNC_FIRST);
    seq.push_back(SYNC_SECOND);
    repeat (4 + $urandom_range(0, 10)) seq.push_back(8'($urandom));
    cut = $urandom_range(0, seq.size() - 1);
    for (int i = 0; i <= cut; i++) send_byte(seq[i], i == cut);
  endtask

  task automatic send_noise(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(7))
        0: b = SYNC_FIRST;
        1: b = SYNC_SECOND;
        default: b = 8'($urandom);
      endcase
      send_byte(b, $urandom_range(19) == 0);
    end
  endtask

  initial begin
    int unsigned pick, lens, plen;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.stream_end <= 1'b0;
    cur_row <= '0;
    ph = PH_HUNT;
    len_q = '0;
    left_q = '0;
    fa = '0;
    fb = '0;
    ck_a_q = '0;
    cls_q = '0;
    id_q = '0;
    good_q = '0;
    bad_q = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) drive_row(plan[i]);
    drain_results();

    while (bytes_sent < PLAN_ROWS + RAND_BYTES) begin
      gaps_on = !(bytes_sent >= 900 && bytes_sent < 1300);
      pick = $urandom_range(99);
      if (pick < 62) begin
        lens = $urandom_range(99);
        plen = (lens < 85) ? $urandom_range(12) :
               (lens < 98) ? $urandom_range(13, 64) : $urandom_range(200, 400);
        send_frame(plen, ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0,
                   $urandom_range(4) == 0, $urandom_range(9) == 0);
      end else if (pick < 80) begin
        send_cut_frame();
      end else begin
        send_noise($urandom_range(1, 8));
      end
      if ($urandom_range(39) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d bytes in %0d transactions back.", bytes_sent, results_seen);
    $display("Frames closed: %0d ok, %0d checksum errors, %0d cut short by stream end.",
             ok_seen, sum_err_seen, cut_seen);
    if (mismatches == 0 && frame_results_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ubx_pkg.sv
rtl/core/ubx_ifs.sv
rtl/core/ubx_frame_deframer.sv
rtl/core/ubx_chk.sv
bench/tb_top.sv
